### rtl/n2a_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package n2a_pkg;

    localparam int VALUE_WIDTH = 64;
    localparam int IN_VALUE_W  = 64;
    localparam int CHAR_W      = 7;

    // ceil(VALUE_WIDTH * log10(2)), upper bound on decimal digits
    localparam int DEC_DIGITS  = (VALUE_WIDTH * 1233) / 4096 + 1;
    localparam int BCD_W       = DEC_DIGITS * 4;
    localparam int HEX_DIGITS  = (VALUE_WIDTH + 3) / 4;
    localparam int HEX_W       = HEX_DIGITS * 4;
    localparam int CNT_W       = $clog2(VALUE_WIDTH + 1);

    localparam logic [CHAR_W-1:0] ASCII_ZERO = 7'h30;
    localparam logic [CHAR_W-1:0] ASCII_X    = 7'h78;
    localparam logic [CHAR_W-1:0] ASCII_A    = 7'h41;

    typedef struct packed {
        logic                  kind;
        logic [IN_VALUE_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic [CHAR_W-1:0] ascii_char;
        logic              last;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_DEC,
        ST_HEX0,
        ST_HEX1,
        ST_HEXD
    } t_state;

    typedef enum logic [1:0] {
        CH_ZERO,
        CH_X,
        CH_BCD,
        CH_HEX
    } t_char_sel;

    typedef struct packed {
        logic      load;
        logic      dabble;
        logic      bcd_shift;
        logic      hex_shift;
        logic      emit;
        t_char_sel sel;
        logic      last;
    } t_dp_cmd;

    typedef struct packed {
        logic out_valid;
        logic bcd_top_zero;
    } t_dp_sts;

    function automatic logic [CHAR_W-1:0] hex_glyph(input logic [3:0] nib);
        logic [CHAR_W-1:0] g;
        if (nib < 4'd10) begin
            g = ASCII_ZERO + {3'b000, nib};
        end else begin
            g = ASCII_A + {3'b000, nib} - 7'd10;
        end
        return g;
    endfunction

endpackage

`default_nettype wire

### rtl/n2a_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module n2a_datapath (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire n2a_pkg::t_in_item   i_in_data,
    input  wire n2a_pkg::t_dp_cmd    i_cmd,
    input  wire logic                i_out_ready,
    output n2a_pkg::t_dp_sts         o_sts,
    output logic                     o_out_valid,
    output n2a_pkg::t_out_item       o_out_data
);
    import n2a_pkg::*;

    logic [HEX_W-1:0]  r_val, n_val;
    logic [BCD_W-1:0]  r_bcd, n_bcd;
    logic [BCD_W-1:0]  adj;
    logic              r_out_valid;
    t_out_item         r_out_data, n_out_data;

    // add 3 to every digit of 5 or more before the shift
    always_comb begin
        for (int i = 0; i < DEC_DIGITS; i++) begin
            if (r_bcd[i*4 +: 4] >= 4'd5) begin
                adj[i*4 +: 4] = r_bcd[i*4 +: 4] + 4'd3;
            end else begin
                adj[i*4 +: 4] = r_bcd[i*4 +: 4];
            end
        end
    end

    always_comb begin
        n_val = r_val;
        n_bcd = r_bcd;
        if (i_cmd.load) begin
            n_val = HEX_W'(i_in_data.value[VALUE_WIDTH-1:0]);
            n_bcd = '0;
        end else if (i_cmd.dabble) begin
            n_bcd = {adj[BCD_W-2:0], r_val[VALUE_WIDTH-1]};
            n_val = {r_val[HEX_W-2:0], 1'b0};
        end else if (i_cmd.bcd_shift) begin
            n_bcd = {r_bcd[BCD_W-5:0], 4'h0};
        end else if (i_cmd.hex_shift) begin
            n_val = {r_val[HEX_W-5:0], 4'h0};
        end
    end

    always_comb begin
        n_out_data.last = i_cmd.last;
        unique case (i_cmd.sel)
            CH_ZERO: n_out_data.ascii_char = ASCII_ZERO;
            CH_X:    n_out_data.ascii_char = ASCII_X;
            CH_BCD:  n_out_data.ascii_char = ASCII_ZERO + {3'b000, r_bcd[BCD_W-1 -: 4]};
            CH_HEX:  n_out_data.ascii_char = hex_glyph(r_val[HEX_W-1 -: 4]);
            default: n_out_data.ascii_char = ASCII_ZERO;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
        r_bcd <= n_bcd;
        if (i_cmd.emit) begin
            r_out_data <= n_out_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_sts.out_valid    = r_out_valid;
    assign o_sts.bcd_top_zero = (r_bcd[BCD_W-1 -: 4] == 4'h0);
    assign o_out_valid        = r_out_valid;
    assign o_out_data         = r_out_data;

endmodule

`default_nettype wire

### rtl/n2a_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module n2a_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic              i_in_kind,
    input  wire logic              i_out_ready,
    input  wire n2a_pkg::t_dp_sts  i_sts,
    output logic                   o_in_ready,
    output n2a_pkg::t_dp_cmd       o_cmd
);
    import n2a_pkg::*;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             slot_free;

    // output register can take a beat this cycle
    assign slot_free = !i_sts.out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.sel  = CH_ZERO;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_in_kind) begin
                        n_state = ST_HEX0;
                    end else begin
                        n_state = ST_CONV;
                        n_cnt   = CNT_W'(VALUE_WIDTH);
                    end
                end
            end
            ST_CONV: begin
                o_cmd.dabble = 1'b1;
                n_cnt        = r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    n_state = ST_SKIP;
                    n_cnt   = CNT_W'(DEC_DIGITS);
                end
            end
            ST_SKIP: begin
                // drop leading zeros, keep at least one digit
                if (i_sts.bcd_top_zero && r_cnt != CNT_W'(1)) begin
                    o_cmd.bcd_shift = 1'b1;
                    n_cnt           = r_cnt - 1'b1;
                end else begin
                    n_state = ST_DEC;
                end
            end
            ST_DEC: begin
                o_cmd.sel = CH_BCD;
                if (slot_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.bcd_shift = 1'b1;
                    o_cmd.last      = (r_cnt == CNT_W'(1));
                    n_cnt           = r_cnt - 1'b1;
                    if (r_cnt == CNT_W'(1)) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_HEX0: begin
                o_cmd.sel = CH_ZERO;
                if (slot_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_HEX1;
                end
            end
            ST_HEX1: begin
                o_cmd.sel = CH_X;
                if (slot_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_HEXD;
                    n_cnt      = CNT_W'(HEX_DIGITS);
                end
            end
            ST_HEXD: begin
                o_cmd.sel = CH_HEX;
                if (slot_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.hex_shift = 1'b1;
                    o_cmd.last      = (r_cnt == CNT_W'(1));
                    n_cnt           = r_cnt - 1'b1;
                    if (r_cnt == CNT_W'(1)) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/number_to_ascii_digits_top.sv
// number_to_ascii_digits_top: renders an unsigned number as ASCII text.
// Input channel (i_in_valid / o_in_ready / i_in_data) takes one beat per
// number: kind selects decimal (0) or hex with a 0x prefix (1). Output
// channel (o_out_valid / i_out_ready / o_out_data) gives one beat per
// character, most significant first, with last set on the final one.
// Decimal: a shift-and-add-3 loop runs one step per value bit, then
// leading zeros are dropped, then one character per cycle while the
// receiver takes them; without stalls the time from accept to the final
// character is the same whatever the digit count, and the controller is
// idle again once the final character is registered.
// Hex: 18 characters, one per cycle while the receiver takes them.
// One number is converted at a time; o_in_ready is high only while the
// controller is idle, which includes the cycle where the final character
// still sits in the output register.
// A stalled receiver holds the output register and the controller waits;
// nothing is dropped. Reset empties the output register and returns the
// controller to idle, abandoning any run in progress.
`timescale 1ns / 1ps
`default_nettype none

module number_to_ascii_digits_top (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire n2a_pkg::t_in_item   i_in_data,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output n2a_pkg::t_out_item       o_out_data
);
    import n2a_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    n2a_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_kind   (i_in_data.kind),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_in_ready  (o_in_ready),
        .o_cmd       (cmd)
    );

    n2a_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .i_out_ready (i_out_ready),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire
